FILE: hw/rtl/sm4_pkg.sv
// ----------------------------------------------------------------------------
// sm4_pkg: shared types, constants and functions
// SM4 S-box, FK/CK key schedule constants, linear transforms, register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sm4_pkg;

    localparam int ROUNDS    = 32;
    localparam int RND_CNT_W = $clog2(ROUNDS);
    localparam int WORD_W    = 32;
    localparam int HALF_W    = 64;
    localparam int CFG_IDX_W = 8;

    localparam logic [RND_CNT_W-1:0] ROUND_LAST = RND_CNT_W'(ROUNDS - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW   = CFG_IDX_W'(3);

    typedef struct packed {
        logic [HALF_W-1:0] key_high;
        logic [HALF_W-1:0] key_low;
        logic [HALF_W-1:0] iv_high;
        logic [HALF_W-1:0] iv_low;
    } t_cfg;

    typedef enum logic {
        RM_DATA,
        RM_KEY
    } t_round_mode;

    localparam logic [WORD_W-1:0] FK [4] = '{
        32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
    };

    localparam logic [7:0] SBOX [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    // byte-wise S-box substitution
    function automatic logic [WORD_W-1:0] tau(input logic [WORD_W-1:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // data path: B ^ B<<<2 ^ B<<<10 ^ B<<<18 ^ B<<<24
    function automatic logic [WORD_W-1:0] l_data(input logic [WORD_W-1:0] b);
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    // key schedule: B ^ B<<<13 ^ B<<<23
    function automatic logic [WORD_W-1:0] l_key(input logic [WORD_W-1:0] b);
        return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

    // CK[i] byte j = (4*i + j) * 7 mod 256
    function automatic logic [WORD_W-1:0] ck_word(input logic [RND_CNT_W-1:0] idx);
        logic [WORD_W-1:0] w;
        logic [7:0]        base;
        int                j;
        w    = '0;
        base = {1'b0, idx, 2'b00};
        for (j = 0; j < 4; j++) begin
            w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
        end
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sm4_if.sv
// ----------------------------------------------------------------------------
// sm4 channel interfaces
// Valid/ready channels for plaintext items, ciphertext items and config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sm4_in_if;
    logic                        valid;
    logic                        ready;
    logic [sm4_pkg::HALF_W-1:0]  plain_high;
    logic [sm4_pkg::HALF_W-1:0]  plain_low;
    logic                        message_start;

    modport source (output valid, plain_high, plain_low, message_start, input ready);
    modport sink   (input valid, plain_high, plain_low, message_start, output ready);
endinterface

interface sm4_out_if;
    logic                        valid;
    logic                        ready;
    logic [sm4_pkg::HALF_W-1:0]  cipher_high;
    logic [sm4_pkg::HALF_W-1:0]  cipher_low;

    modport source (output valid, cipher_high, cipher_low, input ready);
    modport sink   (input valid, cipher_high, cipher_low, output ready);
endinterface

interface sm4_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sm4_pkg::CFG_IDX_W-1:0] index;
    logic [sm4_pkg::HALF_W-1:0]    wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sm4_cfg_regs.sv
// ----------------------------------------------------------------------------
// sm4_cfg_regs: configuration register file
// Holds key and IV; flags key writes so the round keys get re-expanded.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_cfg_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    sm4_cfg_if.sink           i_cfg,
    output sm4_pkg::t_cfg     o_cfg,
    output logic              o_key_wr
);

    sm4_pkg::t_cfg r_cfg;
    sm4_pkg::t_cfg n_cfg;
    logic          wr;

    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid && i_cfg.ready;

    always_comb begin
        n_cfg    = r_cfg;
        o_key_wr = 1'b0;
        if (wr) begin
            case (i_cfg.index)
                sm4_pkg::CFG_KEY_HIGH: begin
                    n_cfg.key_high = i_cfg.wdata;
                    o_key_wr       = 1'b1;
                end
                sm4_pkg::CFG_KEY_LOW: begin
                    n_cfg.key_low = i_cfg.wdata;
                    o_key_wr      = 1'b1;
                end
                sm4_pkg::CFG_IV_HIGH: n_cfg.iv_high = i_cfg.wdata;
                sm4_pkg::CFG_IV_LOW:  n_cfg.iv_low  = i_cfg.wdata;
                default: ; // unused index: dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hw/rtl/sm4_round.sv
// ----------------------------------------------------------------------------
// sm4_round: shared SM4 round unit
// One round of either the cipher or the key schedule, picked by mode.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_round (
    input  wire sm4_pkg::t_round_mode           i_mode,
    input  wire logic [sm4_pkg::WORD_W-1:0]     i_w0,
    input  wire logic [sm4_pkg::WORD_W-1:0]     i_w1,
    input  wire logic [sm4_pkg::WORD_W-1:0]     i_w2,
    input  wire logic [sm4_pkg::WORD_W-1:0]     i_w3,
    input  wire logic [sm4_pkg::WORD_W-1:0]     i_rk,
    output logic      [sm4_pkg::WORD_W-1:0]     o_next
);

    logic [sm4_pkg::WORD_W-1:0] b;
    logic [sm4_pkg::WORD_W-1:0] lin;

    always_comb begin
        b = sm4_pkg::tau(i_w1 ^ i_w2 ^ i_w3 ^ i_rk);
        case (i_mode)
            sm4_pkg::RM_DATA: lin = sm4_pkg::l_data(b);
            sm4_pkg::RM_KEY:  lin = sm4_pkg::l_key(b);
            default:          lin = sm4_pkg::l_data(b);
        endcase
        o_next = i_w0 ^ lin;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sm4_cbc_encryptor.sv
// ----------------------------------------------------------------------------
// sm4_cbc_encryptor: SM4-CBC encryption on one shared round unit.
// Each accepted block runs the 32 cipher rounds in S_CRYPT before its result
// is valid; a new block is accepted only back in S_IDLE, after the last round.
// First block after reset or a key write first runs the 32-round key expansion;
// a result still held by the sink stalls the last round until taken.
// Sync active-low reset: key, IV and chaining value zero, round keys stale.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_cbc_encryptor (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sm4_cfg_if.sink     i_cfg,
    sm4_in_if.sink      i_in,
    sm4_out_if.source   o_out
);

    localparam int W  = sm4_pkg::WORD_W;
    localparam int HW = sm4_pkg::HALF_W;
    localparam int CW = sm4_pkg::RND_CNT_W;

    // Sequencer states:
    //   S_IDLE   - waits for an item, latches plaintext ^ chaining value
    //   S_EXPAND - one key-schedule round per cycle, writes the key store
    //   S_CRYPT  - one cipher round per cycle; the last round writes the
    //              output register (stalls there while it is still full)
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXPAND,
        S_CRYPT
    } t_state;

    // ---------------- configuration ----------------
    sm4_pkg::t_cfg cfg;
    logic          key_wr;

    sm4_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_cfg    (cfg),
        .o_key_wr (key_wr)
    );

    // ---------------- state ----------------
    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_keys_ok, n_keys_ok;      // round key store is current
    logic [HW-1:0]       r_chain_hi, n_chain_hi;
    logic [HW-1:0]       r_chain_lo, n_chain_lo;
    logic                r_out_valid, n_out_valid;
    logic [HW-1:0]       r_cipher_hi, n_cipher_hi;
    logic [HW-1:0]       r_cipher_lo, n_cipher_lo;
    logic [3:0][W-1:0]   r_x, n_x;                  // cipher words x0..x3
    logic [3:0][W-1:0]   r_k, n_k;                  // key schedule words k0..k3

    // round key store, registered read of the key for the next round
    logic [W-1:0]        r_rk_mem [sm4_pkg::ROUNDS];
    logic [W-1:0]        r_rk;
    logic                rk_we;

    // ---------------- shared round unit ----------------
    sm4_pkg::t_round_mode rmode;
    logic [W-1:0]         rw0, rw1, rw2, rw3, rkey;
    logic [W-1:0]         u_next;

    logic                 in_acc;
    logic                 out_free;
    logic [HW-1:0]        chain_hi, chain_lo;
    logic [HW-1:0]        blk_hi, blk_lo;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    // output register can take a new result this cycle
    assign out_free   = !r_out_valid || o_out.ready;

    // In expansion the unit runs on the key words with CK as the round
    // constant; otherwise on the data words with the stored round key.
    always_comb begin
        if (r_state == S_EXPAND) begin
            rmode = sm4_pkg::RM_KEY;
            rw0   = r_k[0];
            rw1   = r_k[1];
            rw2   = r_k[2];
            rw3   = r_k[3];
            rkey  = sm4_pkg::ck_word(r_cnt);
        end else begin
            rmode = sm4_pkg::RM_DATA;
            rw0   = r_x[0];
            rw1   = r_x[1];
            rw2   = r_x[2];
            rw3   = r_x[3];
            rkey  = r_rk;
        end
    end

    sm4_round u_round (
        .i_mode (rmode),
        .i_w0   (rw0),
        .i_w1   (rw1),
        .i_w2   (rw2),
        .i_w3   (rw3),
        .i_rk   (rkey),
        .o_next (u_next)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_keys_ok   = r_keys_ok;
        n_chain_hi  = r_chain_hi;
        n_chain_lo  = r_chain_lo;
        n_out_valid = r_out_valid && !o_out.ready;
        n_cipher_hi = r_cipher_hi;
        n_cipher_lo = r_cipher_lo;
        n_x         = r_x;
        n_k         = r_k;
        rk_we       = 1'b0;

        // message start reloads the chaining value from the IV
        chain_hi = i_in.message_start ? cfg.iv_high : r_chain_hi;
        chain_lo = i_in.message_start ? cfg.iv_low  : r_chain_lo;
        blk_hi   = i_in.plain_high ^ chain_hi;
        blk_lo   = i_in.plain_low  ^ chain_lo;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_chain_hi = chain_hi;
                    n_chain_lo = chain_lo;
                    n_x        = {blk_lo[31:0], blk_lo[63:32], blk_hi[31:0], blk_hi[63:32]};
                    n_k        = {cfg.key_low[31:0]   ^ sm4_pkg::FK[3],
                                  cfg.key_low[63:32]  ^ sm4_pkg::FK[2],
                                  cfg.key_high[31:0]  ^ sm4_pkg::FK[1],
                                  cfg.key_high[63:32] ^ sm4_pkg::FK[0]};
                    n_cnt      = '0;
                    n_state    = r_keys_ok ? S_CRYPT : S_EXPAND;
                end
            end
            S_EXPAND: begin
                rk_we = 1'b1;
                n_k   = {u_next, r_k[3], r_k[2], r_k[1]};
                n_cnt = r_cnt + 1'b1;          // wraps to round 0 at the end
                if (r_cnt == sm4_pkg::ROUND_LAST) begin
                    n_keys_ok = 1'b1;
                    n_state   = S_CRYPT;
                end
            end
            S_CRYPT: begin
                if (r_cnt != sm4_pkg::ROUND_LAST) begin
                    n_x   = {u_next, r_x[3], r_x[2], r_x[1]};
                    n_cnt = r_cnt + 1'b1;
                end else if (out_free) begin
                    // last round: reversed word order straight into the
                    // output register and the chaining value
                    n_cipher_hi = {u_next, r_x[3]};
                    n_cipher_lo = {r_x[2], r_x[1]};
                    n_chain_hi  = {u_next, r_x[3]};
                    n_chain_lo  = {r_x[2], r_x[1]};
                    n_out_valid = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a key write invalidates the stored round keys
        if (key_wr) begin
            n_keys_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_k         <= n_k;
        r_cipher_hi <= n_cipher_hi;
        r_cipher_lo <= n_cipher_lo;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_keys_ok   <= 1'b0;
            r_chain_hi  <= '0;
            r_chain_lo  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_keys_ok   <= n_keys_ok;
            r_chain_hi  <= n_chain_hi;
            r_chain_lo  <= n_chain_lo;
            r_out_valid <= n_out_valid;
        end
    end

    // key store: written during expansion, read one round ahead
    always_ff @(posedge i_clk) begin
        if (rk_we) begin
            r_rk_mem[r_cnt] <= u_next;
        end
        r_rk <= r_rk_mem[n_cnt];
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.cipher_high = r_cipher_hi;
    assign o_out.cipher_low  = r_cipher_lo;

`ifndef SYNTHESIS
    // one item in flight: accepting drops ready on the next cycle
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("item accepted while busy");

    // a result appears only after the final cipher round
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_CRYPT && r_cnt == sm4_pkg::ROUND_LAST))
        else $error("result without final round");

    // finishing expansion marks the key store current and starts the cipher
    a_expand_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXPAND && r_cnt == sm4_pkg::ROUND_LAST && !key_wr
        |=> r_keys_ok && r_state == S_CRYPT && r_cnt == '0)
        else $error("expansion did not hand over");

    // a key write forces a new expansion
    a_key_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_wr |=> !r_keys_ok)
        else $error("stale round keys kept after key write");

    // a pending result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_cipher_hi)
                                        && $stable(r_cipher_lo))
        else $error("pending result lost");
`endif

endmodule

`default_nettype wire

FILE: dv/sm4_cbc_encryptor_test.sv
// ----------------------------------------------------------------------------
// sm4_cbc_encryptor_test: self-checking bench for the SM4 CBC encryptor
// Drives plaintext items and register writes, predicts every ciphertext item
// with an independent SM4/CBC model and compares the results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_cbc_encryptor_test;

    localparam int NUM_ROUNDS       = 32;
    localparam int RANDOM_ITEMS     = 1630;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES     = 80;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int MAX_REPORTS      = 10;

    typedef logic [31:0]                   word_t;
    typedef logic [sm4_pkg::HALF_W-1:0]    half_t;
    typedef logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index_t;

    typedef struct packed {
        half_t high;
        half_t low;
        logic  start;
    } plain_item_t;

    typedef struct packed {
        half_t high;
        half_t low;
    } cipher_t;

    localparam word_t FK_WORDS [4] = '{
        32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
    };

    localparam logic [7:0] SBOX_TABLE [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sm4_in_if  plain_ch ();
    sm4_out_if cipher_ch ();
    sm4_cfg_if cfg_ch ();

    sm4_cbc_encryptor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (plain_ch),
        .o_out   (cipher_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow of the block: registers, round keys, chaining value
    half_t   cfg_key_high = '0;
    half_t   cfg_key_low  = '0;
    half_t   cfg_iv_high  = '0;
    half_t   cfg_iv_low   = '0;
    word_t   round_keys [NUM_ROUNDS];
    logic    keys_ready   = 1'b0;
    cipher_t chain        = '0;

    plain_item_t plain_pending [$];
    cipher_t     cipher_expected [$];

    int   plain_queued       = 0;
    int   plain_accepted     = 0;
    int   mismatch_count     = 0;
    int   stall_cycles       = 0;
    int   plain_gap_left     = 0;
    int   sink_stall_left    = 0;
    int   long_hold_requests = 0;
    int   long_holds_done    = 0;
    logic plain_fire         = 1'b0;

    function automatic word_t rotl(word_t v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic word_t sub_bytes(word_t v);
        return {SBOX_TABLE[v[31:24]], SBOX_TABLE[v[23:16]],
                SBOX_TABLE[v[15:8]], SBOX_TABLE[v[7:0]]};
    endfunction

    // CK word i: byte j is (4*i + j) * 7 mod 256
    function automatic word_t ck_const(int i);
        word_t w;
        int    j;
        w = '0;
        for (j = 0; j < 4; j++) begin
            w = (w << 8) | word_t'(((4 * i + j) * 7) & 255);
        end
        return w;
    endfunction

    function automatic void expand_round_keys();
        word_t k [4];
        word_t b;
        int    i;
        k[0] = cfg_key_high[63:32] ^ FK_WORDS[0];
        k[1] = cfg_key_high[31:0]  ^ FK_WORDS[1];
        k[2] = cfg_key_low[63:32]  ^ FK_WORDS[2];
        k[3] = cfg_key_low[31:0]   ^ FK_WORDS[3];
        for (i = 0; i < NUM_ROUNDS; i++) begin
            b = sub_bytes(k[1] ^ k[2] ^ k[3] ^ ck_const(i));
            round_keys[i] = k[0] ^ b ^ rotl(b, 13) ^ rotl(b, 23);
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = round_keys[i];
        end
        keys_ready = 1'b1;
    endfunction

    // One CBC step: expand keys if stale, chain, 32 rounds, reverse words.
    function automatic cipher_t predict_cipher(plain_item_t item);
        word_t   x [4];
        word_t   b;
        word_t   nx;
        half_t   hi;
        half_t   lo;
        cipher_t res;
        int      i;
        if (!keys_ready) begin
            expand_round_keys();
        end
        if (item.start) begin
            chain = '{cfg_iv_high, cfg_iv_low};
        end
        hi = item.high ^ chain.high;
        lo = item.low ^ chain.low;
        x[0] = hi[63:32];
        x[1] = hi[31:0];
        x[2] = lo[63:32];
        x[3] = lo[31:0];
        for (i = 0; i < NUM_ROUNDS; i++) begin
            b  = sub_bytes(x[1] ^ x[2] ^ x[3] ^ round_keys[i]);
            nx = x[0] ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nx;
        end
        res.high = {x[3], x[2]};
        res.low  = {x[1], x[0]};
        chain    = res;
        return res;
    endfunction

    // mostly zero, a few short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    // random 64-bit value with a bias toward corners
    function automatic half_t pick_value64();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return half_t'(1) << $urandom_range(0, 63);
            end
            3: begin
                return ~(half_t'(1) << $urandom_range(0, 63));
            end
            default: begin
                return {$urandom(), $urandom()};
            end
        endcase
    endfunction

    function automatic void flag_mismatch(string field, half_t want, half_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
        end
    endfunction

    function automatic void push_plain(half_t hi, half_t lo, logic start);
        plain_pending.push_back('{hi, lo, start});
        plain_queued++;
    endfunction

    // the block is idle once every queued item went in and every result came out
    task automatic wait_drained();
        while (plain_queued != plain_accepted || cipher_expected.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input half_t val);
        @(negedge i_clk);
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        cfg_ch.valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (cfg_ch.ready !== 1'b1);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Plaintext driver: holds an item until taken, then waits out a random gap.
    always @(negedge i_clk) begin : plain_driver
        plain_item_t nxt;
        if (!i_rst_n) begin
            plain_ch.valid <= 1'b0;
        end else if (!plain_ch.valid || plain_fire) begin
            if (plain_gap_left > 0) begin
                plain_gap_left--;
                plain_ch.valid <= 1'b0;
            end else if (plain_pending.size() != 0) begin
                nxt = plain_pending.pop_front();
                plain_ch.plain_high    <= nxt.high;
                plain_ch.plain_low     <= nxt.low;
                plain_ch.message_start <= nxt.start;
                plain_ch.valid         <= 1'b1;
                plain_gap_left = pick_gap();
            end else begin
                plain_ch.valid <= 1'b0;
            end
        end
    end

    // Ciphertext sink: random stalls, plus long hold-offs on request so that
    // the block backs up and stops taking plaintext.
    always @(negedge i_clk) begin : cipher_sink
        if (!i_rst_n) begin
            cipher_ch.ready <= 1'b0;
        end else if (sink_stall_left > 0) begin
            sink_stall_left--;
            cipher_ch.ready <= 1'b0;
        end else if (long_holds_done != long_hold_requests) begin
            long_holds_done++;
            sink_stall_left = LONG_HOLD_CYCLES - 1;
            cipher_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 80) begin
            cipher_ch.ready <= 1'b1;
        end else begin
            sink_stall_left = pick_gap();
            cipher_ch.ready <= 1'b0;
        end
    end

    // Monitor: mirrors register writes, predicts on each plaintext item,
    // checks each ciphertext item against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        plain_item_t taken;
        cipher_t     got;
        cipher_t     want;
        logic        any_fire;
        plain_fire = i_rst_n && plain_ch.valid && plain_ch.ready;
        any_fire   = plain_fire;
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            any_fire = 1'b1;
            case (cfg_ch.index)
                sm4_pkg::CFG_KEY_HIGH: begin
                    cfg_key_high = cfg_ch.wdata;
                    keys_ready   = 1'b0;
                end
                sm4_pkg::CFG_KEY_LOW: begin
                    cfg_key_low = cfg_ch.wdata;
                    keys_ready  = 1'b0;
                end
                sm4_pkg::CFG_IV_HIGH: begin
                    cfg_iv_high = cfg_ch.wdata;
                end
                sm4_pkg::CFG_IV_LOW: begin
                    cfg_iv_low = cfg_ch.wdata;
                end
                default: begin
                end
            endcase
        end
        if (plain_fire) begin
            taken = '{plain_ch.plain_high, plain_ch.plain_low, plain_ch.message_start};
            cipher_expected.push_back(predict_cipher(taken));
            plain_accepted++;
        end
        if (i_rst_n && cipher_ch.valid && cipher_ch.ready) begin
            any_fire = 1'b1;
            got = '{cipher_ch.cipher_high, cipher_ch.cipher_low};
            if (cipher_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected ciphertext item %h %h",
                             $time, got.high, got.low);
                end
            end else begin
                want = cipher_expected.pop_front();
                if (got.high !== want.high) begin
                    flag_mismatch("cipher_high", want.high, got.high);
                end
                if (got.low !== want.low) begin
                    flag_mismatch("cipher_low", want.low, got.low);
                end
            end
        end
        if (any_fire) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", stall_cycles);
            $display("sm4_cbc_encryptor: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        cipher_t kat;
        half_t   v;
        logic    start;
        int      n;
        int      k;
        int      pause_at;
        int      phase;
        int      random_items;

        plain_ch.valid         = 1'b0;
        plain_ch.plain_high    = '0;
        plain_ch.plain_low     = '0;
        plain_ch.message_start = 1'b0;
        cipher_ch.ready        = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = '0;
        cfg_ch.wdata           = '0;

        // sanity of the local cipher tables against the published SM4 vector,
        // then back to the reset state
        cfg_key_high = 64'h0123456789abcdef;
        cfg_key_low  = 64'hfedcba9876543210;
        kat = predict_cipher('{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1});
        if (kat !== {64'h681edf34d206965e, 64'h86b3e94f536e4246}) begin
            mismatch_count++;
            $display("local SM4 tables disagree with the standard vector: %h", kat);
        end
        cfg_key_high = '0;
        cfg_key_low  = '0;
        keys_ready   = 1'b0;
        chain        = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // straight out of reset: zero key expanded on first use, zero chain
        push_plain('0, '0, 1'b0);
        push_plain('1, '1, 1'b0);
        push_plain('0, '0, 1'b1);
        wait_drained();

        // standard key, zero IV: first block is plain SM4
        write_reg(sm4_pkg::CFG_KEY_HIGH, 64'h0123456789abcdef);
        write_reg(sm4_pkg::CFG_KEY_LOW, 64'hfedcba9876543210);
        push_plain(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
        push_plain('1, '0, 1'b0);
        push_plain('0, '1, 1'b0);
        wait_drained();

        // new IV mid-message: chain keeps running until the next start
        write_reg(sm4_pkg::CFG_IV_HIGH, '1);
        write_reg(sm4_pkg::CFG_IV_LOW, '1);
        push_plain(64'h8000000000000000, 64'h0000000000000001, 1'b0);
        push_plain(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
        push_plain(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b1);
        push_plain('0, '0, 1'b0);
        wait_drained();

        // rekey mid-message, and writes to unused indexes that must do nothing
        write_reg(sm4_pkg::CFG_KEY_LOW, 64'h8000000000000001);
        write_reg(sm4_pkg::CFG_IV_LOW + cfg_index_t'(1), '1);
        write_reg('1, '0);
        push_plain('1, '1, 1'b0);
        push_plain('0, '0, 1'b0);
        wait_drained();

        // all-ones key, odd IV
        write_reg(sm4_pkg::CFG_KEY_HIGH, '1);
        write_reg(sm4_pkg::CFG_KEY_LOW, '1);
        write_reg(sm4_pkg::CFG_IV_HIGH, '0);
        write_reg(sm4_pkg::CFG_IV_LOW, 64'h1);
        push_plain('1, '1, 1'b1);
        push_plain('0, '0, 1'b0);
        push_plain('1, '0, 1'b1);

        // Random phases: new settings between phases, messages of random
        // length inside. Every 14th phase from phase 3 holds off the sink for a long
        // stretch; some stop feeding halfway until everything has come out.
        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_drained();
            if (phase < 2) begin
                v = (phase == 0) ? '0 : '1;
                write_reg(sm4_pkg::CFG_KEY_HIGH, v);
                write_reg(sm4_pkg::CFG_KEY_LOW, v);
                write_reg(sm4_pkg::CFG_IV_HIGH, v);
                write_reg(sm4_pkg::CFG_IV_LOW, v);
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(sm4_pkg::CFG_KEY_HIGH, pick_value64());
                end
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(sm4_pkg::CFG_KEY_LOW, pick_value64());
                end
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(sm4_pkg::CFG_IV_HIGH, pick_value64());
                end
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(sm4_pkg::CFG_IV_LOW, pick_value64());
                end
                if ($urandom_range(0, 4) == 0) begin
                    write_reg(cfg_index_t'($urandom_range(4, 255)), pick_value64());
                end
            end
            n        = $urandom_range(20, 80);
            pause_at = (phase % 5 == 2) ? n / 2 : -1;
            for (k = 0; k < n; k++) begin
                if (k == pause_at) begin
                    wait_drained();
                end
                if (k == 0) begin
                    start = ($urandom_range(0, 7) != 0);
                end else begin
                    start = ($urandom_range(0, 9) == 0);
                end
                push_plain(pick_value64(), pick_value64(), start);
                if (phase % 14 == 3 && k == 0) begin
                    long_hold_requests++;
                end
            end
            random_items += n;
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && cipher_expected.size() == 0) begin
            $display("sm4_cbc_encryptor: match");
        end else begin
            $display("sm4_cbc_encryptor: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
